>>> hw/rtl/abbs_pkg.sv
// Package with the shared types and constants of the alarm beep and blink sequencer.
`timescale 1ns / 1ps

package abbs_pkg;

    typedef enum logic [1:0] {
        PH_OVER = 2'd0,
        PH_NEW  = 2'd1,
        PH_RING = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_NEW  = 2'd1,
        OP_STOP = 2'd2
    } t_opcode;

    localparam logic [1:0] CFG_BEEP_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_BLINK_TICKS   = 2'd1;
    localparam logic [1:0] CFG_BUZZER_PERMIT = 2'd2;

    localparam int CfgDataWidth = 16;

    localparam logic [7:0]  MAX_GROUPS          = 8'd8;
    localparam logic [7:0]  VOICE_KEEP_A        = 8'd1;
    localparam logic [7:0]  VOICE_KEEP_B        = 8'd2;
    localparam logic [7:0]  RST_BEEP_INTERVAL   = 8'd1;
    localparam logic [15:0] RST_BLINK_TICKS     = 16'd120;

endpackage

>>> hw/rtl/alarm_beep_blink_sequencer.sv
// Top level of the alarm beep and blink sequencer.
`timescale 1ns / 1ps

// One transaction is accepted in every clock cycle in which o_in_stall is low.
// Each transaction's result is computed in a single pass from the alarm state and
// the input fields and lands in the output register as it is accepted. The input
// side stalls only while that register holds a result that the downstream side is
// stalling on. Configuration writes take effect at the next clock edge.
module alarm_beep_blink_sequencer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [abbs_pkg::CfgDataWidth-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_opcode,
    input  logic                                  i_key_pressed,
    input  logic                                  i_hint_more,
    input  logic [7:0]                            i_beep_count,
    input  logic [7:0]                            i_voice_select,
    input  logic [7:0]                            i_group_number,
    input  logic                                  i_has_hint,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_buzzer_on,
    output logic                                  o_led_on,
    output logic                                  o_voice_valid,
    output logic [7:0]                            o_voice_out,
    output logic                                  o_info_valid,
    output logic [3:0]                            o_info_point,
    output logic                                  o_hint_request,
    output logic [1:0]                            o_alarm_phase,
    output logic                                  o_external_alarm
);

    logic [7:0]  r_beep_interval;
    logic [15:0] r_blink_ticks;
    logic        r_buzzer_permit;

    abbs_pkg::t_phase r_phase, n_phase, w_tick_phase;
    logic [7:0]  r_beeps_left, n_beeps_left;
    logic [7:0]  r_beep_delay, n_beep_delay;
    logic        r_buzzer_level, n_buzzer_level;
    logic        r_buzzer_done, n_buzzer_done;
    logic        r_hint_done, n_hint_done;
    logic        r_led_level, n_led_level;
    logic        r_led_done, n_led_done;
    logic [15:0] r_blink_left, n_blink_left;
    logic [7:0]  r_stored_count, n_stored_count;
    logic [7:0]  r_stored_voice, n_stored_voice;
    logic [7:0]  r_stored_group, n_stored_group;
    logic        r_hint_attached, n_hint_attached;
    logic        r_ext_flag, n_ext_flag;

    logic        r_out_valid;
    logic        r_voice_valid, n_voice_valid;
    logic [7:0]  r_voice_out, n_voice_out;
    logic        r_info_valid, n_info_valid;
    logic [3:0]  r_info_point, n_info_point;
    logic        r_hint_request, n_hint_request;
    logic        r_buzzer_on;
    logic        r_led_on;
    logic [1:0]  r_alarm_phase;
    logic        r_external_alarm;

    logic        w_accept;
    logic        w_voice_start;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    // A key press on a tick ends the alarm before the phase is evaluated.
    assign w_tick_phase = i_key_pressed ? abbs_pkg::PH_OVER : r_phase;

    assign w_voice_start = (r_beeps_left != 8'd0) && (r_beep_delay == r_beep_interval);

    // Next state of the alarm.
    always_comb begin
        n_phase         = r_phase;
        n_beeps_left    = r_beeps_left;
        n_beep_delay    = r_beep_delay;
        n_buzzer_level  = r_buzzer_level;
        n_buzzer_done   = r_buzzer_done;
        n_hint_done     = r_hint_done;
        n_led_level     = r_led_level;
        n_led_done      = r_led_done;
        n_blink_left    = r_blink_left;
        n_stored_count  = r_stored_count;
        n_stored_voice  = r_stored_voice;
        n_stored_group  = r_stored_group;
        n_hint_attached = r_hint_attached;
        n_ext_flag      = r_ext_flag;
        case (i_opcode)
            abbs_pkg::OP_NEW: begin
                n_stored_voice = i_voice_select;
                n_stored_count = i_beep_count;
                n_phase        = abbs_pkg::PH_NEW;
                if (i_voice_select != abbs_pkg::VOICE_KEEP_A &&
                    i_voice_select != abbs_pkg::VOICE_KEEP_B) begin
                    n_stored_group  = i_group_number;
                    n_hint_attached = i_has_hint;
                end
            end
            abbs_pkg::OP_STOP: begin
                n_hint_attached = 1'b0;
                n_phase         = abbs_pkg::PH_OVER;
                n_stored_count  = 8'd0;
            end
            abbs_pkg::OP_TICK: begin
                if (i_key_pressed && r_phase != abbs_pkg::PH_OVER) begin
                    n_stored_count = 8'd0;
                end
                case (w_tick_phase)
                    abbs_pkg::PH_OVER: begin
                        n_phase        = abbs_pkg::PH_OVER;
                        n_buzzer_level = 1'b0;
                        n_led_level    = 1'b0;
                        n_hint_done    = 1'b1;
                        n_buzzer_done  = 1'b1;
                        n_led_done     = 1'b1;
                    end
                    abbs_pkg::PH_NEW: begin
                        if (r_hint_attached && i_hint_more) begin
                            n_hint_done = 1'b0;
                        end else begin
                            n_hint_done     = 1'b1;
                            n_hint_attached = 1'b0;
                        end
                        n_buzzer_level = 1'b1;
                        n_beeps_left   = r_stored_count - 8'd1;
                        n_beep_delay   = r_beep_interval;
                        n_buzzer_done  = 1'b0;
                        n_led_level    = 1'b1;
                        n_led_done     = 1'b0;
                        n_blink_left   = r_blink_ticks;
                        n_phase        = abbs_pkg::PH_RING;
                    end
                    abbs_pkg::PH_RING: begin
                        if (r_beeps_left != 8'd0) begin
                            if (w_voice_start) begin
                                n_ext_flag = 1'b1;
                            end
                            if (r_beep_delay == 8'd0) begin
                                n_buzzer_level = ~r_buzzer_level;
                                if (r_buzzer_level) begin
                                    n_beeps_left = r_beeps_left - 8'd1;
                                end
                                n_beep_delay = r_beep_interval;
                            end else begin
                                n_beep_delay = r_beep_delay - 8'd1;
                            end
                        end else if (!r_buzzer_done) begin
                            n_buzzer_level = 1'b0;
                            n_buzzer_done  = 1'b1;
                        end
                        if (!r_hint_done && !(r_hint_attached && i_hint_more)) begin
                            n_hint_done     = 1'b1;
                            n_hint_attached = 1'b0;
                        end
                        if (r_blink_left != 16'd0) begin
                            n_led_level  = ~r_led_level;
                            n_blink_left = r_blink_left - 16'd1;
                        end else if (!r_led_done) begin
                            n_led_level = 1'b0;
                            n_led_done  = 1'b1;
                        end
                        if (n_hint_done && n_buzzer_done && n_led_done) begin
                            n_phase = abbs_pkg::PH_OVER;
                        end
                    end
                    default: begin
                        n_phase = abbs_pkg::PH_OVER;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Event outputs of the transaction.
    always_comb begin
        n_voice_valid  = 1'b0;
        n_voice_out    = 8'd0;
        n_info_valid   = 1'b0;
        n_info_point   = 4'd0;
        n_hint_request = 1'b0;
        case (i_opcode)
            abbs_pkg::OP_STOP: begin
                n_info_valid = 1'b1;
            end
            abbs_pkg::OP_TICK: begin
                if (i_key_pressed) begin
                    n_voice_valid = 1'b1;
                    if (r_phase != abbs_pkg::PH_OVER) begin
                        n_info_valid = 1'b1;
                    end
                end
                case (w_tick_phase)
                    abbs_pkg::PH_NEW: begin
                        n_hint_request = r_hint_attached;
                        n_info_valid   = 1'b1;
                        if (r_stored_group < abbs_pkg::MAX_GROUPS) begin
                            n_info_point = 4'(r_stored_group + 8'd1);
                        end
                    end
                    abbs_pkg::PH_RING: begin
                        if (w_voice_start) begin
                            n_voice_valid = 1'b1;
                            n_voice_out   = r_stored_voice;
                        end
                        n_hint_request = ~r_hint_done & r_hint_attached;
                        if (n_phase == abbs_pkg::PH_OVER) begin
                            n_info_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_hint_request = 1'b0;
                    end
                endcase
            end
            default: begin
                n_voice_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_interval <= abbs_pkg::RST_BEEP_INTERVAL;
            r_blink_ticks   <= abbs_pkg::RST_BLINK_TICKS;
            r_buzzer_permit <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                abbs_pkg::CFG_BEEP_INTERVAL: r_beep_interval <= i_cfg_data[7:0];
                abbs_pkg::CFG_BLINK_TICKS:   r_blink_ticks   <= i_cfg_data[15:0];
                abbs_pkg::CFG_BUZZER_PERMIT: r_buzzer_permit <= i_cfg_data[0];
                default:                     r_buzzer_permit <= r_buzzer_permit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= abbs_pkg::PH_OVER;
            r_beeps_left    <= 8'd0;
            r_beep_delay    <= 8'd0;
            r_buzzer_level  <= 1'b1;
            r_buzzer_done   <= 1'b1;
            r_hint_done     <= 1'b1;
            r_led_level     <= 1'b1;
            r_led_done      <= 1'b1;
            r_blink_left    <= 16'd0;
            r_stored_count  <= 8'd0;
            r_stored_voice  <= 8'd0;
            r_stored_group  <= 8'd0;
            r_hint_attached <= 1'b0;
            r_ext_flag      <= 1'b0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_beeps_left    <= n_beeps_left;
            r_beep_delay    <= n_beep_delay;
            r_buzzer_level  <= n_buzzer_level;
            r_buzzer_done   <= n_buzzer_done;
            r_hint_done     <= n_hint_done;
            r_led_level     <= n_led_level;
            r_led_done      <= n_led_done;
            r_blink_left    <= n_blink_left;
            r_stored_count  <= n_stored_count;
            r_stored_voice  <= n_stored_voice;
            r_stored_group  <= n_stored_group;
            r_hint_attached <= n_hint_attached;
            r_ext_flag      <= n_ext_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buzzer_on      <= n_buzzer_level & r_buzzer_permit;
            r_led_on         <= n_led_level;
            r_voice_valid    <= n_voice_valid;
            r_voice_out      <= n_voice_out;
            r_info_valid     <= n_info_valid;
            r_info_point     <= n_info_point;
            r_hint_request   <= n_hint_request;
            r_alarm_phase    <= n_phase;
            r_external_alarm <= n_ext_flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_buzzer_on      = r_buzzer_on;
    assign o_led_on         = r_led_on;
    assign o_voice_valid    = r_voice_valid;
    assign o_voice_out      = r_voice_out;
    assign o_info_valid     = r_info_valid;
    assign o_info_point     = r_info_point;
    assign o_hint_request   = r_hint_request;
    assign o_alarm_phase    = r_alarm_phase;
    assign o_external_alarm = r_external_alarm;

    // An accepted transaction always leaves a result in the output register.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted transaction left no result");

    // A nonzero info point is only shown as the alarm starts ringing.
    a_info_point_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_info_point != 4'd0) |->
        (r_alarm_phase == abbs_pkg::PH_RING && r_info_valid))
        else $error("info point shown outside the start of ringing");

    // A voice interval start always sets the external alarm flag.
    a_voice_sets_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_voice_valid && r_voice_out != 8'd0) |-> r_external_alarm)
        else $error("voice played without the external alarm flag");

endmodule

>>> test/tb.sv
// Self-checking testbench for the alarm beep and blink sequencer.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MaxReported = 10;
    localparam int CfgW = abbs_pkg::CfgDataWidth;

    typedef struct packed {
        logic [1:0] opcode;
        logic       key_pressed;
        logic       hint_more;
        logic [7:0] beep_count;
        logic [7:0] voice_select;
        logic [7:0] group_number;
        logic       has_hint;
    } t_alarm_item;

    typedef struct packed {
        logic       buzzer_on;
        logic       led_on;
        logic       voice_valid;
        logic [7:0] voice_out;
        logic       info_valid;
        logic [3:0] info_point;
        logic       hint_request;
        logic [1:0] alarm_phase;
        logic       external_alarm;
    } t_alarm_outputs;

    class t_scoreboard;
        logic [7:0]  beep_interval;
        logic [15:0] blink_ticks;
        logic        buzzer_permit;
        abbs_pkg::t_phase phase;
        logic [7:0]  beeps_left;
        logic [7:0]  beep_delay;
        logic        buzzer_level;
        logic        buzzer_done;
        logic        hint_done;
        logic        led_level;
        logic        led_done;
        logic [15:0] blink_left;
        logic [7:0]  stored_count;
        logic [7:0]  stored_voice;
        logic [7:0]  stored_group;
        logic        hint_attached;
        logic        ext_flag;
        t_alarm_outputs pending_outputs[$];
        int failures;

        function new();
            beep_interval = abbs_pkg::RST_BEEP_INTERVAL;
            blink_ticks = abbs_pkg::RST_BLINK_TICKS;
            buzzer_permit = 1'b1;
            phase = abbs_pkg::PH_OVER;
            beeps_left = '0;
            beep_delay = '0;
            buzzer_level = 1'b1;
            buzzer_done = 1'b1;
            hint_done = 1'b1;
            led_level = 1'b1;
            led_done = 1'b1;
            blink_left = '0;
            stored_count = '0;
            stored_voice = '0;
            stored_group = '0;
            hint_attached = 1'b0;
            ext_flag = 1'b0;
            failures = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CfgW-1:0] value);
            case (idx)
                abbs_pkg::CFG_BEEP_INTERVAL: beep_interval = value[7:0];
                abbs_pkg::CFG_BLINK_TICKS:   blink_ticks = value[15:0];
                abbs_pkg::CFG_BUZZER_PERMIT: buzzer_permit = value[0];
                default: ;
            endcase
        endfunction

        // The hint counts as finished once the source is absent or stops refreshing.
        function logic poll_hint(logic more);
            logic consulted;
            consulted = hint_attached;
            if (!(hint_attached && more)) begin
                hint_done = 1'b1;
                hint_attached = 1'b0;
            end
            return consulted;
        endfunction

        function string describe(t_alarm_outputs o);
            return {$sformatf("buzzer=%0b led=%0b voice=%0b/%0d ",
                              o.buzzer_on, o.led_on, o.voice_valid, o.voice_out),
                    $sformatf("info=%0b/%0d hint=%0b phase=%0d ext=%0b",
                              o.info_valid, o.info_point, o.hint_request, o.alarm_phase,
                              o.external_alarm)};
        endfunction

        function void accept_item(t_alarm_item it);
            t_alarm_outputs o;
            o = '0;
            case (it.opcode)
                abbs_pkg::OP_NEW: begin
                    stored_voice = it.voice_select;
                    stored_count = it.beep_count;
                    phase = abbs_pkg::PH_NEW;
                    if (it.voice_select != abbs_pkg::VOICE_KEEP_A &&
                        it.voice_select != abbs_pkg::VOICE_KEEP_B) begin
                        stored_group = it.group_number;
                        hint_attached = it.has_hint;
                    end
                end
                abbs_pkg::OP_STOP: begin
                    o.info_valid = 1'b1;
                    hint_attached = 1'b0;
                    phase = abbs_pkg::PH_OVER;
                    stored_count = '0;
                end
                abbs_pkg::OP_TICK: begin
                    if (it.key_pressed) begin
                        if (phase != abbs_pkg::PH_OVER) begin
                            o.info_valid = 1'b1;
                            stored_count = '0;
                            phase = abbs_pkg::PH_OVER;
                        end
                        o.voice_valid = 1'b1;
                    end
                    case (phase)
                        abbs_pkg::PH_OVER: begin
                            buzzer_level = 1'b0;
                            led_level = 1'b0;
                            hint_done = 1'b1;
                            buzzer_done = 1'b1;
                            led_done = 1'b1;
                        end
                        abbs_pkg::PH_NEW: begin
                            hint_done = 1'b0;
                            o.hint_request = poll_hint(it.hint_more);
                            o.info_valid = 1'b1;
                            o.info_point = (stored_group < abbs_pkg::MAX_GROUPS) ?
                                           stored_group[3:0] + 4'd1 : 4'd0;
                            buzzer_level = 1'b1;
                            beeps_left = stored_count - 8'd1;
                            beep_delay = beep_interval;
                            buzzer_done = 1'b0;
                            led_level = 1'b1;
                            led_done = 1'b0;
                            blink_left = blink_ticks;
                            phase = abbs_pkg::PH_RING;
                        end
                        abbs_pkg::PH_RING: begin
                            if (beeps_left != 8'd0) begin
                                if (beep_delay == beep_interval) begin
                                    o.voice_valid = 1'b1;
                                    o.voice_out = stored_voice;
                                    ext_flag = 1'b1;
                                end
                                if (beep_delay == 8'd0) begin
                                    buzzer_level = ~buzzer_level;
                                    if (!buzzer_level) beeps_left = beeps_left - 8'd1;
                                    beep_delay = beep_interval;
                                end else begin
                                    beep_delay = beep_delay - 8'd1;
                                end
                            end else if (!buzzer_done) begin
                                buzzer_level = 1'b0;
                                buzzer_done = 1'b1;
                            end
                            if (!hint_done) o.hint_request = poll_hint(it.hint_more);
                            if (blink_left > 16'd0) begin
                                led_level = ~led_level;
                                blink_left = blink_left - 16'd1;
                            end else if (!led_done) begin
                                led_level = 1'b0;
                                led_done = 1'b1;
                            end
                            if (hint_done && buzzer_done && led_done) begin
                                phase = abbs_pkg::PH_OVER;
                                o.info_valid = 1'b1;
                                o.info_point = 4'd0;
                            end
                        end
                        default: phase = abbs_pkg::PH_OVER;
                    endcase
                end
                default: ;
            endcase
            o.buzzer_on = buzzer_level & buzzer_permit;
            o.led_on = led_level;
            o.alarm_phase = phase;
            o.external_alarm = ext_flag;
            pending_outputs.push_back(o);
        endfunction

        function void check_outputs(t_alarm_outputs got);
            t_alarm_outputs want;
            if (pending_outputs.size() == 0) begin
                failures++;
                if (failures <= MaxReported)
                    $display("unexpected transaction on the output: %s", describe(got));
                return;
            end
            want = pending_outputs.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= MaxReported)
                    $display("mismatch: expected %s, actual %s", describe(want), describe(got));
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_index;
    logic [CfgW-1:0]         i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [1:0]              i_opcode;
    logic                    i_key_pressed;
    logic                    i_hint_more;
    logic [7:0]              i_beep_count;
    logic [7:0]              i_voice_select;
    logic [7:0]              i_group_number;
    logic                    i_has_hint;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_buzzer_on;
    logic                    o_led_on;
    logic                    o_voice_valid;
    logic [7:0]              o_voice_out;
    logic                    o_info_valid;
    logic [3:0]              o_info_point;
    logic                    o_hint_request;
    logic [1:0]              o_alarm_phase;
    logic                    o_external_alarm;

    bit idle_enabled = 1'b1;
    t_scoreboard sb = new();

    alarm_beep_blink_sequencer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_key_pressed    (i_key_pressed),
        .i_hint_more      (i_hint_more),
        .i_beep_count     (i_beep_count),
        .i_voice_select   (i_voice_select),
        .i_group_number   (i_group_number),
        .i_has_hint       (i_has_hint),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_buzzer_on      (o_buzzer_on),
        .o_led_on         (o_led_on),
        .o_voice_valid    (o_voice_valid),
        .o_voice_out      (o_voice_out),
        .o_info_valid     (o_info_valid),
        .o_info_point     (o_info_point),
        .o_hint_request   (o_hint_request),
        .o_alarm_phase    (o_alarm_phase),
        .o_external_alarm (o_external_alarm)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= idle_enabled && ($urandom_range(99) < 24);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_outputs({o_buzzer_on, o_led_on, o_voice_valid, o_voice_out, o_info_valid,
                              o_info_point, o_hint_request, o_alarm_phase, o_external_alarm});
        end
    end

    task automatic send_item(input t_alarm_item it);
        if (idle_enabled && $urandom_range(99) < 13) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_opcode = it.opcode;
        i_key_pressed = it.key_pressed;
        i_hint_more = it.hint_more;
        i_beep_count = it.beep_count;
        i_voice_select = it.voice_select;
        i_group_number = it.group_number;
        i_has_hint = it.has_hint;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.accept_item(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending_outputs.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_alarm_item random_alarm();
        t_alarm_item it;
        logic [31:0] r;
        r = $urandom;
        it = r[28:0];
        it.opcode = abbs_pkg::OP_NEW;
        if ($urandom_range(9) < 8) it.beep_count = 8'($urandom_range(4, 1));
        if ($urandom_range(9) < 2) it.voice_select = 8'($urandom_range(2, 1));
        if ($urandom_range(9) < 7) it.group_number = 8'($urandom_range(9));
        return it;
    endfunction

    function automatic t_alarm_item random_tick(int key_pct);
        t_alarm_item it;
        logic [31:0] r;
        r = $urandom;
        it = r[28:0];
        it.opcode = abbs_pkg::OP_TICK;
        it.key_pressed = ($urandom_range(99) < key_pct);
        it.hint_more = ($urandom_range(99) < 75);
        return it;
    endfunction

    // Mostly complete alarms (a new alarm followed by ticks), with stray transactions mixed in.
    task automatic run_alarms(input int n_items, input int max_ticks);
        int sent;
        int ticks;
        t_alarm_item it;
        logic [31:0] r;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                r = $urandom;
                it = r[28:0];
                send_item(it);
                sent++;
            end else begin
                send_item(random_alarm());
                ticks = $urandom_range(max_ticks, 1);
                repeat (ticks) begin
                    it = random_tick(3);
                    if ($urandom_range(99) < 2) it.opcode = abbs_pkg::OP_STOP;
                    send_item(it);
                end
                sent += ticks + 1;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = abbs_pkg::CFG_BEEP_INTERVAL;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = abbs_pkg::OP_TICK;
        i_key_pressed = 1'b0;
        i_hint_more = 1'b0;
        i_beep_count = '0;
        i_voice_select = '0;
        i_group_number = '0;
        i_has_hint = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{OP_UNUSED, 1'b1, 1'b1, 8'hAA, 8'h55, 8'hAA, 1'b1});
        send_item(t_alarm_item'{abbs_pkg::OP_NEW, 1'b1, 1'b0, 8'd0, 8'd5, 8'd7, 1'b1});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
        repeat (3)
            send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_STOP, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_NEW, 1'b0, 1'b0, 8'd255, 8'd255, 8'd8, 1'b0});
        repeat (2)
            send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_NEW, 1'b0, 1'b0, 8'd1, 8'd1, 8'd255, 1'b1});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_NEW, 1'b0, 1'b0, 8'd2, 8'd2, 8'd0, 1'b1});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_NEW, 1'b0, 1'b0, 8'd1, 8'd0, 8'd255, 1'b1});
        send_item(t_alarm_item'{abbs_pkg::OP_TICK, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0});
        send_item(t_alarm_item'{abbs_pkg::OP_STOP, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
        wait_drained();

        write_reg(abbs_pkg::CFG_BEEP_INTERVAL, 16'd0);
        write_reg(abbs_pkg::CFG_BLINK_TICKS, 16'd3);
        write_reg(abbs_pkg::CFG_BUZZER_PERMIT, 16'd0);
        run_alarms(80, 12);
        wait_drained();
        run_alarms(30, 12);
        wait_drained();

        write_reg(abbs_pkg::CFG_BEEP_INTERVAL, 16'd255);
        write_reg(abbs_pkg::CFG_BLINK_TICKS, 16'd0);
        write_reg(abbs_pkg::CFG_BUZZER_PERMIT, 16'd1);
        run_alarms(60, 20);
        wait_drained();

        write_reg(abbs_pkg::CFG_BEEP_INTERVAL, 16'd2);
        write_reg(abbs_pkg::CFG_BLINK_TICKS, 16'd65535);
        run_alarms(60, 30);
        wait_drained();

        write_reg(abbs_pkg::CFG_BEEP_INTERVAL, CfgW'($urandom_range(3)));
        write_reg(abbs_pkg::CFG_BLINK_TICKS, CfgW'($urandom_range(12)));
        idle_enabled = 1'b0;
        run_alarms(85, 15);
        idle_enabled = 1'b1;
        run_alarms(85, 15);
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending_outputs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/abbs_pkg.sv
hw/rtl/alarm_beep_blink_sequencer.sv
test/tb.sv
